// ----- rtl/core/c8alu_pkg.sv -----
`default_nettype none

package c8alu_pkg;

    // Operation codes carried in the low bits of each input beat.
    typedef enum logic [4:0] {
        OP_LDA   = 5'd0,
        OP_ADD   = 5'd1,
        OP_ADC   = 5'd2,
        OP_SUB   = 5'd3,
        OP_SBC   = 5'd4,
        OP_AND   = 5'd5,
        OP_XOR   = 5'd6,
        OP_OR    = 5'd7,
        OP_CP    = 5'd8,
        OP_INC   = 5'd9,
        OP_DEC   = 5'd10,
        OP_DAA   = 5'd11,
        OP_CPL   = 5'd12,
        OP_CCF   = 5'd13,
        OP_SCF   = 5'd14,
        OP_RLC   = 5'd15,
        OP_RRC   = 5'd16,
        OP_RL    = 5'd17,
        OP_RR    = 5'd18,
        OP_SLA   = 5'd19,
        OP_SRA   = 5'd20,
        OP_SWAP  = 5'd21,
        OP_SRL   = 5'd22,
        OP_BIT   = 5'd23,
        OP_RES   = 5'd24,
        OP_SET   = 5'd25,
        OP_ADD16 = 5'd26,
        OP_ADDSP = 5'd27,
        OP_LDF   = 5'd28
    } op_t;

    localparam int IN_W  = 48;
    localparam int OUT_W = 40;

    // BCD adjust constants.
    localparam logic [7:0] DAA_HI  = 8'h60;
    localparam logic [7:0] DAA_LO  = 8'h06;
    localparam logic [7:0] BCD_MAX = 8'h99;

    // Input beat layout, first field in the highest bits.
    typedef struct packed {
        logic [15:0] word_addend;
        logic [15:0] word_base;
        logic [2:0]  bit_index;
        logic [7:0]  operand;
        logic [4:0]  op;
    } in_item_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    // Output beat layout, first field in the highest bits.
    typedef struct packed {
        logic [3:0]  pad;
        logic        flag_c;
        logic        flag_h;
        logic        flag_n;
        logic        flag_z;
        logic [7:0]  acc_out;
        logic [15:0] word_result;
        logic [7:0]  byte_result;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/cpu8_alu_with_flags.sv -----
// An input beat passes through the input register and then the output register,
// which holds it until the sink takes it. Throughput: one beat per cycle while
// the sink does not stall; an operation uses the A and flags left by the
// previous one, all updated in the single pass between the input and output
// registers. Reset (rst_n low, asynchronous) clears A, the flags and both
// valid bits; the data registers are not reset.
`default_nettype none

module cpu8_alu_with_flags (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // s_tdata, from bit 0: op[4:0], operand[7:0], bit_index[2:0],
    // word_base[15:0], word_addend[15:0]
    input  wire logic [c8alu_pkg::IN_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // m_tdata, from bit 0: byte_result[7:0], word_result[15:0], acc_out[7:0],
    // flag_z, flag_n, flag_h, flag_c, four zero bits of padding
    output logic [c8alu_pkg::OUT_W-1:0]      m_tdata
);

    // Input stage register. It captures a beat whenever it is empty or its
    // current contents move on to the output register in the same cycle.
    logic                  in_vld_reg;
    c8alu_pkg::in_item_t   in_data_reg;

    // Output register, which keeps a finished beat while the sink stalls.
    logic                  out_vld_reg;
    c8alu_pkg::out_item_t  out_data_reg;

    // Architectural state: accumulator and the Z/N/H/C flags.
    logic [7:0]            acc_reg;
    c8alu_pkg::flags_t     flags_reg;

    logic [7:0]            acc_next;
    c8alu_pkg::flags_t     flags_next;
    c8alu_pkg::out_item_t  out_next;

    logic                  out_free;
    logic                  advance;

    // The output register can take a new beat when it is empty or being drained.
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            acc_reg     <= 8'h00;
            flags_reg   <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_vld_reg <= in_vld_reg;
            end
            // The state moves with the beat, so the next operation sees it.
            if (advance)
            begin
                acc_reg   <= acc_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= c8alu_pkg::in_item_t'(s_tdata);
        end
        if (advance)
        begin
            out_data_reg <= out_next;
        end
    end

    // Operation datapath: one pass over narrow adders, shifters and muxes.
    logic [7:0]  v;
    logic [2:0]  bi;
    logic [15:0] wb;
    logic [15:0] wa;
    logic        cin;
    logic        carry_in;
    logic [8:0]  add_sum;
    logic [4:0]  add_half;
    logic [8:0]  sub_diff;
    logic [4:0]  sub_half;
    logic [16:0] w16_sum;
    logic [12:0] w12_sum;
    logic [8:0]  sp_low;
    logic [4:0]  sp_half;
    logic [15:0] sp_sum;
    logic [7:0]  daa_val;
    logic        daa_hi_fix;
    logic [7:0]  bit_mask;
    logic [7:0]  byte_r;
    logic [15:0] word_r;

    always_comb
    begin
        v   = in_data_reg.operand;
        bi  = in_data_reg.bit_index;
        wb  = in_data_reg.word_base;
        wa  = in_data_reg.word_addend;
        cin = flags_reg.c;

        // Carry in is used only by adc and sbc.
        carry_in = cin && (c8alu_pkg::op_t'(in_data_reg.op) == c8alu_pkg::OP_ADC ||
                           c8alu_pkg::op_t'(in_data_reg.op) == c8alu_pkg::OP_SBC);

        add_sum  = {1'b0, acc_reg} + {1'b0, v} + {8'h00, carry_in};
        add_half = {1'b0, acc_reg[3:0]} + {1'b0, v[3:0]} + {4'h0, carry_in};
        // Bit 8 / bit 4 of the difference is the borrow.
        sub_diff = {1'b0, acc_reg} - {1'b0, v} - {8'h00, carry_in};
        sub_half = {1'b0, acc_reg[3:0]} - {1'b0, v[3:0]} - {4'h0, carry_in};

        w16_sum = {1'b0, wb} + {1'b0, wa};
        w12_sum = {1'b0, wb[11:0]} + {1'b0, wa[11:0]};

        // SP plus a signed byte; H and C come from the unsigned low byte add.
        sp_low  = {1'b0, wb[7:0]} + {1'b0, v};
        sp_half = {1'b0, wb[3:0]} + {1'b0, v[3:0]};
        sp_sum  = wb + {{8{v[7]}}, v};

        // Decimal adjust. Adding 0x60 leaves the low nibble untouched, so the
        // low correction can look at the original low nibble.
        daa_hi_fix = flags_reg.c || (acc_reg > c8alu_pkg::BCD_MAX);
        if (!flags_reg.n)
        begin
            daa_val = acc_reg
                    + (daa_hi_fix ? c8alu_pkg::DAA_HI : 8'h00)
                    + ((flags_reg.h || (acc_reg[3:0] > 4'h9)) ? c8alu_pkg::DAA_LO : 8'h00);
        end
        else
        begin
            daa_val = acc_reg
                    - (flags_reg.c ? c8alu_pkg::DAA_HI : 8'h00)
                    - (flags_reg.h ? c8alu_pkg::DAA_LO : 8'h00);
        end

        bit_mask = 8'h01 << bi;

        acc_next   = acc_reg;
        flags_next = flags_reg;
        byte_r     = 8'h00;
        word_r     = 16'h0000;

        case (c8alu_pkg::op_t'(in_data_reg.op))
            c8alu_pkg::OP_LDA:
            begin
                acc_next = v;
                byte_r   = v;
            end
            c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC:
            begin
                acc_next   = add_sum[7:0];
                flags_next = '{z: (add_sum[7:0] == 8'h00), n: 1'b0,
                               h: add_half[4], c: add_sum[8]};
                byte_r     = add_sum[7:0];
            end
            c8alu_pkg::OP_SUB, c8alu_pkg::OP_SBC:
            begin
                acc_next   = sub_diff[7:0];
                flags_next = '{z: (sub_diff[7:0] == 8'h00), n: 1'b1,
                               h: sub_half[4], c: sub_diff[8]};
                byte_r     = sub_diff[7:0];
            end
            c8alu_pkg::OP_CP:
            begin
                // Compare sets the flags of a subtract and keeps A.
                flags_next = '{z: (sub_diff[7:0] == 8'h00), n: 1'b1,
                               h: sub_half[4], c: sub_diff[8]};
                byte_r     = acc_reg;
            end
            c8alu_pkg::OP_AND:
            begin
                acc_next   = acc_reg & v;
                flags_next = '{z: ((acc_reg & v) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
                byte_r     = acc_reg & v;
            end
            c8alu_pkg::OP_XOR:
            begin
                acc_next   = acc_reg ^ v;
                flags_next = '{z: ((acc_reg ^ v) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
                byte_r     = acc_reg ^ v;
            end
            c8alu_pkg::OP_OR:
            begin
                acc_next   = acc_reg | v;
                flags_next = '{z: ((acc_reg | v) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
                byte_r     = acc_reg | v;
            end
            c8alu_pkg::OP_INC:
            begin
                byte_r       = v + 8'h01;
                flags_next.z = (v == 8'hFF);
                flags_next.n = 1'b0;
                flags_next.h = (v[3:0] == 4'hF);
            end
            c8alu_pkg::OP_DEC:
            begin
                byte_r       = v - 8'h01;
                flags_next.z = (v == 8'h01);
                flags_next.n = 1'b1;
                flags_next.h = (v[3:0] == 4'h0);
            end
            c8alu_pkg::OP_DAA:
            begin
                acc_next     = daa_val;
                byte_r       = daa_val;
                flags_next.z = (daa_val == 8'h00);
                flags_next.h = 1'b0;
                flags_next.c = flags_reg.n ? flags_reg.c : (flags_reg.c || daa_hi_fix);
            end
            c8alu_pkg::OP_CPL:
            begin
                acc_next     = ~acc_reg;
                byte_r       = ~acc_reg;
                flags_next.n = 1'b1;
                flags_next.h = 1'b1;
            end
            c8alu_pkg::OP_CCF:
            begin
                byte_r       = acc_reg;
                flags_next.n = 1'b0;
                flags_next.h = 1'b0;
                flags_next.c = !flags_reg.c;
            end
            c8alu_pkg::OP_SCF:
            begin
                byte_r       = acc_reg;
                flags_next.n = 1'b0;
                flags_next.h = 1'b0;
                flags_next.c = 1'b1;
            end
            c8alu_pkg::OP_RLC:
            begin
                byte_r     = {v[6:0], v[7]};
                flags_next = '{z: (v == 8'h00), n: 1'b0, h: 1'b0, c: v[7]};
            end
            c8alu_pkg::OP_RRC:
            begin
                byte_r     = {v[0], v[7:1]};
                flags_next = '{z: (v == 8'h00), n: 1'b0, h: 1'b0, c: v[0]};
            end
            c8alu_pkg::OP_RL:
            begin
                byte_r     = {v[6:0], cin};
                flags_next = '{z: ({v[6:0], cin} == 8'h00), n: 1'b0, h: 1'b0, c: v[7]};
            end
            c8alu_pkg::OP_RR:
            begin
                byte_r     = {cin, v[7:1]};
                flags_next = '{z: ({cin, v[7:1]} == 8'h00), n: 1'b0, h: 1'b0, c: v[0]};
            end
            c8alu_pkg::OP_SLA:
            begin
                byte_r     = {v[6:0], 1'b0};
                flags_next = '{z: (v[6:0] == 7'h00), n: 1'b0, h: 1'b0, c: v[7]};
            end
            c8alu_pkg::OP_SRA:
            begin
                byte_r     = {v[7], v[7:1]};
                flags_next = '{z: (v[7:1] == 7'h00), n: 1'b0, h: 1'b0, c: v[0]};
            end
            c8alu_pkg::OP_SWAP:
            begin
                byte_r     = {v[3:0], v[7:4]};
                flags_next = '{z: (v == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            c8alu_pkg::OP_SRL:
            begin
                byte_r     = {1'b0, v[7:1]};
                flags_next = '{z: (v[7:1] == 7'h00), n: 1'b0, h: 1'b0, c: v[0]};
            end
            c8alu_pkg::OP_BIT:
            begin
                byte_r       = v;
                flags_next.z = !v[bi];
                flags_next.n = 1'b0;
                flags_next.h = 1'b1;
            end
            c8alu_pkg::OP_RES:
            begin
                byte_r = v & ~bit_mask;
            end
            c8alu_pkg::OP_SET:
            begin
                byte_r = v | bit_mask;
            end
            c8alu_pkg::OP_ADD16:
            begin
                // Z is kept; H is the carry out of bit 11.
                word_r       = w16_sum[15:0];
                flags_next.n = 1'b0;
                flags_next.h = w12_sum[12];
                flags_next.c = w16_sum[16];
            end
            c8alu_pkg::OP_ADDSP:
            begin
                word_r     = sp_sum;
                flags_next = '{z: 1'b0, n: 1'b0, h: sp_half[4], c: sp_low[8]};
            end
            c8alu_pkg::OP_LDF:
            begin
                flags_next = '{z: v[7], n: v[6], h: v[5], c: v[4]};
                byte_r     = {v[7:4], 4'h0};
            end
            default:
            begin
                // Unused codes leave the state alone and report zero byte and word results.
                byte_r = 8'h00;
            end
        endcase

        out_next.pad         = 4'h0;
        out_next.flag_c      = flags_next.c;
        out_next.flag_h      = flags_next.h;
        out_next.flag_n      = flags_next.n;
        out_next.flag_z      = flags_next.z;
        out_next.acc_out     = acc_next;
        out_next.word_result = word_r;
        out_next.byte_result = byte_r;
    end

    // The accumulator and flags change only when a beat moves to the output.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(acc_reg) && $stable(flags_reg))
        else $error("state changed without a beat moving to the output");

    // A waiting output beat always shows the current accumulator.
    a_acc_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_data_reg.acc_out == acc_reg))
        else $error("output accumulator differs from the state");

    // A waiting output beat always shows the current flags.
    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_data_reg.flag_z == flags_reg.z) &&
                        (out_data_reg.flag_n == flags_reg.n) &&
                        (out_data_reg.flag_h == flags_reg.h) &&
                        (out_data_reg.flag_c == flags_reg.c))
        else $error("output flags differ from the state");

    // The input side stalls only when both registers hold a beat and the sink stalls.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_vld_reg && out_vld_reg && !m_tready)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
